// ===== sv/u8ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// u8ucs_pkg
// Shared types, constants and helpers of the UTF-8 to UCS-2 sanitizer.
// ----------------------------------------------------------------------------
package u8ucs_pkg;

  localparam logic [15:0] ReplChar    = 16'hFFFD;
  localparam logic [15:0] MaxUnitsRst = 16'hFFFF;
  localparam logic [20:0] SurrLo      = 21'h00D800;
  localparam logic [20:0] SurrHi      = 21'h00DFFF;
  localparam logic [20:0] MaxCp       = 21'h10FFFF;
  localparam logic [20:0] BmpMax      = 21'h00FFFF;

  // Config register index (byte address bit 2).
  typedef enum logic [0:0] {
    RegMaxUnits = 1'b0
  } reg_idx_e;

  // One decoded byte, as handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]  n_emit;    // units to send (after the limit)
    logic [2:0]  n_repl;    // leading U+FFFD units in the burst
    logic [15:0] fin_unit;  // unit that follows the replacements
    logic        last;      // send a done item at the end
    logic [15:0] base;      // unit count before this byte
  } job_t;

  function automatic logic [20:0] min_for_len(input logic [2:0] len);
    logic [20:0] lo;
    unique case (len)
      3'd2:    lo = 21'h000080;
      3'd3:    lo = 21'h000800;
      3'd4:    lo = 21'h010000;
      default: lo = 21'h000000;
    endcase
    return lo;
  endfunction

  // Control characters and bidi embedding/isolate controls.
  function automatic logic is_dropped(input logic [20:0] cp);
    return (cp <= 21'h1F) || (cp == 21'h7F) ||
           ((cp >= 21'h80) && (cp <= 21'h9F)) ||
           ((cp >= 21'h202A) && (cp <= 21'h202E)) ||
           ((cp >= 21'h2066) && (cp <= 21'h2069));
  endfunction

  function automatic logic [15:0] unit_of(input logic [20:0] cp);
    return (cp > BmpMax) ? ReplChar : cp[15:0];
  endfunction

endpackage

// ===== sv/u8ucs_front.sv =====
// ----------------------------------------------------------------------------
// u8ucs_front
// Byte decoder: tracks the open sequence and the unit count, and turns
// each byte into at most one burst descriptor.
// ----------------------------------------------------------------------------
module u8ucs_front
  import u8ucs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] max_units_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] pcp_q, pcp_d;
  logic [15:0] emitted_q, emitted_d;

  logic        accept;
  logic        cont;
  logic [2:0]  pend_inc;
  logic [20:0] acc;
  logic [2:0]  n_repl;
  logic        fin_valid;
  logic [15:0] fin_unit;
  logic        use_fresh;
  logic [2:0]  total;
  logic [15:0] room;
  logic [2:0]  n_emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cont       = (in_byte_i[7:6] == 2'b10);
  assign pend_inc   = {1'b0, pend_q} + 3'd1;
  assign acc        = {pcp_q[14:0], in_byte_i[5:0]};

  always_comb begin
    n_repl    = 3'd0;
    fin_valid = 1'b0;
    fin_unit  = 16'h0000;
    use_fresh = 1'b0;
    pend_d    = pend_q;
    len_d     = len_q;
    pcp_d     = pcp_q;

    if (pend_q != 2'd0) begin
      if (cont) begin
        if (pend_inc >= len_q) begin
          pend_d = 2'd0;
          len_d  = 3'd0;
          pcp_d  = 21'd0;
          if ((acc < min_for_len(len_q)) || ((acc >= SurrLo) && (acc <= SurrHi)) ||
              (acc > MaxCp)) begin
            n_repl = len_q;
          end else begin
            fin_valid = !is_dropped(acc);
            fin_unit  = unit_of(acc);
          end
        end else if (last_byte_i) begin
          n_repl = pend_inc;
          pend_d = 2'd0;
          len_d  = 3'd0;
          pcp_d  = 21'd0;
        end else begin
          pend_d = pend_inc[1:0];
          pcp_d  = acc;
        end
      end else begin
        // broken sequence: one replacement per held byte, then decode afresh
        n_repl    = {1'b0, pend_q};
        pend_d    = 2'd0;
        len_d     = 3'd0;
        pcp_d     = 21'd0;
        use_fresh = 1'b1;
      end
    end else begin
      use_fresh = 1'b1;
    end

    if (use_fresh) begin
      if (!in_byte_i[7]) begin
        fin_valid = !is_dropped({13'd0, in_byte_i});
        fin_unit  = {8'd0, in_byte_i};
      end else if ((in_byte_i[7:5] == 3'b110) || (in_byte_i[7:4] == 4'b1110) ||
                   (in_byte_i[7:3] == 5'b11110)) begin
        if (last_byte_i) begin
          n_repl = n_repl + 3'd1;
        end else begin
          pend_d = 2'd1;
          if (in_byte_i[7:5] == 3'b110) begin
            len_d = 3'd2;
            pcp_d = {16'd0, in_byte_i[4:0]};
          end else if (in_byte_i[7:4] == 4'b1110) begin
            len_d = 3'd3;
            pcp_d = {17'd0, in_byte_i[3:0]};
          end else begin
            len_d = 3'd4;
            pcp_d = {18'd0, in_byte_i[2:0]};
          end
        end
      end else begin
        n_repl = n_repl + 3'd1;
      end
    end

    if (last_byte_i) begin
      pend_d = 2'd0;
      len_d  = 3'd0;
      pcp_d  = 21'd0;
    end
  end

  assign total     = n_repl + {2'd0, fin_valid};
  assign room      = (emitted_q < max_units_i) ? (max_units_i - emitted_q) : 16'd0;
  assign n_emit    = (room < {13'd0, total}) ? room[2:0] : total;
  assign emitted_d = last_byte_i ? 16'd0 : (emitted_q + {13'd0, n_emit});

  assign push_o          = accept && ((n_emit != 3'd0) || last_byte_i);
  assign job_o.n_emit    = n_emit;
  assign job_o.n_repl    = n_repl;
  assign job_o.fin_unit  = fin_unit;
  assign job_o.last      = last_byte_i;
  assign job_o.base      = emitted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 2'd0;
      len_q     <= 3'd0;
      pcp_q     <= 21'd0;
      emitted_q <= 16'd0;
    end else if (accept) begin
      pend_q    <= pend_d;
      len_q     <= len_d;
      pcp_q     <= pcp_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// ===== sv/u8ucs_queue.sv =====
// ----------------------------------------------------------------------------
// u8ucs_queue
// Small FIFO of burst descriptors between decoder and result sequencer.
// ----------------------------------------------------------------------------
module u8ucs_queue
  import u8ucs_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/u8ucs_back.sv =====
// ----------------------------------------------------------------------------
// u8ucs_back
// Result sequencer: expands one descriptor into its results, one per
// cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module u8ucs_back
  import u8ucs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        has_unit_o,
  output logic        string_done_o,
  output logic [15:0] unit_count_o,
  output logic        run_end_o
);

  logic        out_valid_q;
  logic [2:0]  idx_q;
  logic [15:0] code_q;
  logic        has_q;
  logic        done_q;
  logic [15:0] count_q;
  logic        end_q;

  logic        load;
  logic        is_unit;
  logic        is_end;
  logic [15:0] code_d;
  logic [15:0] count_d;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_unit = (idx_q < head_i.n_emit);
  // the done item, when present, always closes the burst
  assign is_end  = is_unit ? (((idx_q + 3'd1) == head_i.n_emit) && !head_i.last) : 1'b1;
  assign pop_o   = load && is_end;
  assign code_d  = !is_unit ? 16'h0000 :
                   (idx_q < head_i.n_repl) ? ReplChar : head_i.fin_unit;
  assign count_d = head_i.base + {13'd0, idx_q} + {15'd0, is_unit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= is_end ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q  <= code_d;
      has_q   <= is_unit;
      done_q  <= !is_unit;
      count_q <= count_d;
      end_q   <= is_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_unit_o   = code_q;
  assign has_unit_o    = has_q;
  assign string_done_o = done_q;
  assign unit_count_o  = count_q;
  assign run_end_o     = end_q;

endmodule

// ===== sv/utf8_to_ucs2_sanitizer_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_sanitizer_top
// UTF-8 byte stream in, sanitized UCS-2 code units out.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per input transaction and sends zero to five
// result transactions per byte: code units (malformed input, surrogates,
// overlong forms, out-of-range and non-BMP points become U+FFFD; control and
// bidi control characters vanish), and on the last byte of a string a done
// item carrying the unit count. tlast on the output marks the last result of
// each input byte. Input is taken at one byte per cycle as long as the job
// queue (QueueDepth entries) has room; the result side sends one transaction
// per cycle unless m_axis_tready holds it off, and the queue absorbs the
// bursts of results that one byte can yield. The first result of an input
// transaction passes through the job queue entry, then the output register.
// max_units at byte address 0 caps the units per string; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_sanitizer_top
  import u8ucs_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] code_unit, [31:16] unit_count
  output logic [1:0]  m_axis_tuser,   // [0] has_unit, [1] string_done
  output logic        m_axis_tlast,   // run_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_units_q;
  logic        q_full;
  logic        q_valid;
  logic        push;
  logic        pop;
  job_t        job;
  job_t        head;
  logic        cfg_hit;

  // ---- configuration port ----
  // Register index is byte address bit 2; only index 0 exists.
  assign pready  = 1'b1;
  assign cfg_hit = (reg_idx_e'(paddr[2]) == RegMaxUnits);
  assign prdata  = cfg_hit ? {16'd0, max_units_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= MaxUnitsRst;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      max_units_q <= pwdata[15:0];
    end
  end

  // ---- front end: decode and count, one byte per cycle while the queue has room ----
  u8ucs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_units_i (max_units_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job)
  );

  // ---- descriptor queue: decouples bursts from the byte stream ----
  u8ucs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // ---- back end: one result transaction per cycle unless the output stalls ----
  u8ucs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .code_unit_o   (m_axis_tdata[15:0]),
    .has_unit_o    (m_axis_tuser[0]),
    .string_done_o (m_axis_tuser[1]),
    .unit_count_o  (m_axis_tdata[31:16]),
    .run_end_o     (m_axis_tlast)
  );

endmodule
